[hdl/mshr_pkg.sv]
// Package for the miss status holding register file.
// Holds operation and status codes and default sizes; no dependencies.
package mshr_pkg;

    localparam int unsigned ENTRIES     = 16;
    localparam int unsigned LINE_BYTES  = 64;
    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned ADDR_BITS   = 48;
    localparam int unsigned TAG_BITS    = 16;

    localparam int unsigned KIND_W   = 3;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned OUT_TAG_W = 16;
    localparam int unsigned MAXE_W   = 5;
    localparam int unsigned MAXQ_W   = 4;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 5;

    typedef enum logic [KIND_W-1:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_ENQ   = 3'd2,
        OP_POP   = 3'd3,
        OP_PEEK  = 3'd4,
        OP_SET   = 3'd5,
        OP_CHECK = 3'd6,
        OP_NONE  = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_NOENTRY = 3'd3,
        ST_DUP     = 3'd4,
        ST_OVERRUN = 3'd5
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_QUEUED  = 1'b1;

endpackage

[hdl/mshr_core_logic.sv]
// Single-pass operation logic and state of the miss file.
// Depends on mshr_pkg.
module mshr_core_logic #(
    parameter int unsigned ENTRIES     = mshr_pkg::ENTRIES,
    parameter int unsigned LINE_BYTES  = mshr_pkg::LINE_BYTES,
    parameter int unsigned QUEUE_DEPTH = mshr_pkg::QUEUE_DEPTH,
    parameter int unsigned ADDR_BITS   = mshr_pkg::ADDR_BITS,
    parameter int unsigned TAG_BITS    = mshr_pkg::TAG_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               op_valid,
    input  mshr_pkg::op_t                      op_kind,
    input  logic [ADDR_BITS-1:0]               op_address,
    input  logic [mshr_pkg::COUNT_W-1:0]       op_count,
    input  logic [TAG_BITS-1:0]                op_tag,
    input  logic [mshr_pkg::MAXE_W-1:0]        max_entries,
    input  logic [mshr_pkg::MAXQ_W-1:0]       max_queued,
    output mshr_pkg::status_t                  r_status,
    output logic                               r_hit,
    output logic                               r_all_valid,
    output logic [mshr_pkg::OUT_TAG_W-1:0]     r_tag,
    output logic                               r_tag_present,
    output logic [mshr_pkg::MAXE_W-1:0]        r_in_use,
    output logic                               r_can_alloc,
    output logic                               r_can_enq
);
    localparam int unsigned OFF_W = $clog2(LINE_BYTES);
    localparam int unsigned KEY_W = ADDR_BITS - OFF_W;
    localparam int unsigned E_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned Q_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QC_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned UC_W  = $clog2(ENTRIES + 1);
    localparam int unsigned SUM_W = OFF_W + 2 > mshr_pkg::COUNT_W + 1 ?
                                    OFF_W + 2 : mshr_pkg::COUNT_W + 1;
    localparam int unsigned ELIM_W = UC_W > mshr_pkg::MAXE_W ? UC_W : mshr_pkg::MAXE_W;
    localparam int unsigned QLIM_W = QC_W > mshr_pkg::MAXQ_W ? QC_W : mshr_pkg::MAXQ_W;

    logic [ENTRIES-1:0]                 used_reg, used_next;
    logic [KEY_W-1:0]                   key_reg   [ENTRIES];
    logic [LINE_BYTES-1:0]              marks_reg [ENTRIES];
    logic [Q_W-1:0]                     head_reg  [ENTRIES];
    logic [QC_W-1:0]                    qcnt_reg  [ENTRIES];
    logic [TAG_BITS-1:0]                tags_reg  [ENTRIES][QUEUE_DEPTH];
    logic [TAG_BITS-1:0]                tag_rd_reg;
    logic [UC_W-1:0]                    ucnt_reg, ucnt_next;

    logic [KEY_W-1:0]      key;
    logic [OFF_W-1:0]      offset;
    logic [ENTRIES-1:0]    match;
    logic                  found, free_found;
    logic [E_W-1:0]        e_idx, free_idx, tgt_idx;
    logic [SUM_W-1:0]      end_pos;
    logic                  range_ok;
    logic [LINE_BYTES-1:0] range;
    logic [ELIM_W-1:0]     e_limit;
    logic [QLIM_W-1:0]     q_limit;
    logic [QC_W-1:0]       qc;
    logic [Q_W-1:0]        hd, wr_slot;
    mshr_pkg::status_t     status;
    logic                  hit_o, all_valid_o, tag_present_o, can_enq_o;
    logic                  do_alloc, do_free, do_enq, do_pop, do_set;
    logic [QC_W-1:0]       qc_after;

    assign key    = op_address[ADDR_BITS-1:OFF_W];
    assign offset = op_address[OFF_W-1:0];

    // Look up the key and the lowest free slot
    always_comb begin
        found = 1'b0; e_idx = '0; free_found = 1'b0; free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            match[i] = used_reg[i] && (key_reg[i] == key);
            if (match[i]) begin
                found = 1'b1; e_idx = E_W'(i);
            end
            if (!used_reg[i]) begin
                free_found = 1'b1; free_idx = E_W'(i);
            end
        end
    end

    // Byte range and limits
    always_comb begin
        end_pos  = SUM_W'(offset) + SUM_W'(op_count);
        range_ok = end_pos <= SUM_W'(LINE_BYTES);
        range    = '0;
        for (int b = 0; b < LINE_BYTES; b++)
            range[b] = range_ok && (SUM_W'(b) >= SUM_W'(offset)) && (SUM_W'(b) < end_pos);
        e_limit = (ELIM_W'(max_entries) < ELIM_W'(ENTRIES)) ?
                  ELIM_W'(max_entries) : ELIM_W'(ENTRIES);
        q_limit = (QLIM_W'(max_queued) < QLIM_W'(QUEUE_DEPTH)) ?
                  QLIM_W'(max_queued) : QLIM_W'(QUEUE_DEPTH);
    end

    assign qc = qcnt_reg[e_idx];
    assign hd = head_reg[e_idx];
    always_comb begin
        logic [Q_W:0] s;
        s = {1'b0, hd} + (Q_W+1)'(qc);
        if (s >= (Q_W+1)'(QUEUE_DEPTH)) s = s - (Q_W+1)'(QUEUE_DEPTH);
        wr_slot = s[Q_W-1:0];
    end

    // Decide the operation
    always_comb begin
        status = mshr_pkg::ST_OK;
        do_alloc = 1'b0; do_free = 1'b0; do_enq = 1'b0; do_pop = 1'b0; do_set = 1'b0;
        all_valid_o = 1'b0; tag_present_o = 1'b0;
        hit_o = found; tgt_idx = e_idx; qc_after = qc;
        ucnt_next = ucnt_reg;
        if (op_kind != mshr_pkg::OP_ALLOC && op_kind != mshr_pkg::OP_NONE && !found) begin
            status = mshr_pkg::ST_NOENTRY;
        end else begin
            case (op_kind)
                mshr_pkg::OP_ALLOC: begin
                    if (found) status = mshr_pkg::ST_DUP;
                    else if (ELIM_W'(ucnt_reg) >= e_limit || !free_found)
                        status = mshr_pkg::ST_FULL;
                    else begin
                        do_alloc = 1'b1; hit_o = 1'b1; tgt_idx = free_idx;
                        qc_after = '0; ucnt_next = ucnt_reg + 1'b1;
                    end
                end
                mshr_pkg::OP_FREE: begin
                    do_free = 1'b1; hit_o = 1'b0;
                    if (ucnt_reg != '0) ucnt_next = ucnt_reg - 1'b1;
                end
                mshr_pkg::OP_ENQ: begin
                    if (QLIM_W'(qc) >= q_limit) status = mshr_pkg::ST_FULL;
                    else begin
                        do_enq = 1'b1; qc_after = qc + 1'b1;
                    end
                end
                mshr_pkg::OP_POP, mshr_pkg::OP_PEEK: begin
                    if (qc == '0) status = mshr_pkg::ST_EMPTY;
                    else begin
                        tag_present_o = 1'b1;
                        if (op_kind == mshr_pkg::OP_POP) begin
                            do_pop = 1'b1; qc_after = qc - 1'b1;
                        end
                    end
                end
                mshr_pkg::OP_SET: begin
                    if (!range_ok) status = mshr_pkg::ST_OVERRUN;
                    else do_set = 1'b1;
                end
                mshr_pkg::OP_CHECK: begin
                    if (!range_ok) status = mshr_pkg::ST_OVERRUN;
                    else all_valid_o = ((marks_reg[e_idx] & range) == range);
                end
                default: ;
            endcase
        end
        can_enq_o = hit_o && (QLIM_W'(qc_after) < q_limit);
        used_next = used_reg;
        if (do_alloc) used_next[free_idx] = 1'b1;
        if (do_free)  used_next[e_idx] = 1'b0;
    end

    // Update control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            ucnt_reg <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                head_reg[i] <= '0; qcnt_reg[i] <= '0; marks_reg[i] <= '0;
            end
        end else if (op_valid) begin
            used_reg <= used_next;
            ucnt_reg <= ucnt_next;
            if (do_alloc || do_free) begin
                head_reg[tgt_idx] <= '0; qcnt_reg[tgt_idx] <= '0;
            end
            if (do_alloc) marks_reg[tgt_idx] <= '0;
            if (do_enq) qcnt_reg[e_idx] <= qc_after;
            if (do_pop) begin
                qcnt_reg[e_idx] <= qc_after;
                head_reg[e_idx] <= (32'(hd) + 1 >= QUEUE_DEPTH) ? '0 : hd + 1'b1;
            end
            if (do_set) marks_reg[e_idx] <= marks_reg[e_idx] | range;
        end
    end

    // Hold keys and queued tags; read the head tag into a register
    always_ff @(posedge aclk) begin
        if (op_valid && do_alloc) key_reg[tgt_idx] <= key;
        if (op_valid && do_enq)   tags_reg[e_idx][wr_slot] <= op_tag;
        if (op_valid)             tag_rd_reg <= tags_reg[e_idx][hd];
    end

    assign r_status      = status;
    assign r_hit         = hit_o;
    assign r_all_valid   = all_valid_o;
    assign r_tag         = mshr_pkg::OUT_TAG_W'(tag_rd_reg);
    assign r_tag_present = tag_present_o;
    assign r_in_use      = mshr_pkg::MAXE_W'(ucnt_next);
    assign r_can_alloc   = ELIM_W'(ucnt_next) < e_limit;
    assign r_can_enq     = can_enq_o;
endmodule

[hdl/miss_status_holding_registers_core.sv]
// Top level of the miss status holding register file.
// Depends on mshr_pkg and mshr_core_logic.
//
// Channel   Direction  Handshake
// s_        in         s_valid / s_ready, one request per operation
// m_        out        m_valid / m_ready, one result per request
// cfg_      in         cfg_valid / cfg_ready, register writes
//
// A request is processed in the cycle it is accepted; its result is
// registered and shown the next cycle, so one request per cycle is taken
// unless m_ready stalls. The head tag is read from the tag store into a register
// at the same edge. The result register is the only stage: s_ready is high while
// it is empty or being drained. Synchronous active-low reset empties the table.
module miss_status_holding_registers_core #(
    parameter int unsigned ENTRIES     = mshr_pkg::ENTRIES,
    parameter int unsigned LINE_BYTES  = mshr_pkg::LINE_BYTES,
    parameter int unsigned QUEUE_DEPTH = mshr_pkg::QUEUE_DEPTH,
    parameter int unsigned ADDR_BITS   = mshr_pkg::ADDR_BITS,
    parameter int unsigned TAG_BITS    = mshr_pkg::TAG_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [mshr_pkg::KIND_W-1:0]        s_kind,
    input  logic [ADDR_BITS-1:0]               s_address,
    input  logic [mshr_pkg::COUNT_W-1:0]       s_byte_count,
    input  logic [TAG_BITS-1:0]                s_request_tag,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [mshr_pkg::STATUS_W-1:0]      m_status,
    output logic                               m_hit,
    output logic                               m_all_valid,
    output logic [mshr_pkg::OUT_TAG_W-1:0]     m_tag_out,
    output logic                               m_tag_present,
    output logic [mshr_pkg::MAXE_W-1:0]        m_entries_in_use,
    output logic                               m_can_allocate,
    output logic                               m_can_enqueue,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mshr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mshr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    logic [mshr_pkg::MAXE_W-1:0] max_e_reg;
    logic [mshr_pkg::MAXQ_W-1:0] max_q_reg;
    logic                        out_valid_reg;
    logic                        accept;
    mshr_pkg::status_t           c_status;
    logic                        c_hit, c_av, c_tp, c_ca, c_ce;
    logic [mshr_pkg::OUT_TAG_W-1:0] c_tag;
    logic [mshr_pkg::MAXE_W-1:0] c_use;

    assign s_ready   = !out_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign m_valid   = out_valid_reg;

    mshr_core_logic #(
        .ENTRIES(ENTRIES), .LINE_BYTES(LINE_BYTES), .QUEUE_DEPTH(QUEUE_DEPTH),
        .ADDR_BITS(ADDR_BITS), .TAG_BITS(TAG_BITS)
    ) u_logic (
        .aclk(aclk), .aresetn(aresetn), .op_valid(accept),
        .op_kind(mshr_pkg::op_t'(s_kind)), .op_address(s_address),
        .op_count(s_byte_count), .op_tag(s_request_tag),
        .max_entries(max_e_reg), .max_queued(max_q_reg),
        .r_status(c_status), .r_hit(c_hit), .r_all_valid(c_av), .r_tag(c_tag),
        .r_tag_present(c_tp), .r_in_use(c_use), .r_can_alloc(c_ca),
        .r_can_enq(c_ce)
    );

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_e_reg <= mshr_pkg::MAXE_W'(16);
            max_q_reg <= mshr_pkg::MAXQ_W'(8);
        end else if (cfg_valid) begin
            if (cfg_index == mshr_pkg::REG_MAX_ENTRIES) max_e_reg <= cfg_data;
            else if (cfg_index == mshr_pkg::REG_MAX_QUEUED)
                max_q_reg <= cfg_data[mshr_pkg::MAXQ_W-1:0];
        end
    end

    // Hold the result until drained
    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else if (accept) out_valid_reg <= 1'b1;
        else if (m_ready) out_valid_reg <= 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_status <= c_status; m_hit <= c_hit; m_all_valid <= c_av;
            m_tag_present <= c_tp; m_entries_in_use <= c_use;
            m_can_allocate <= c_ca; m_can_enqueue <= c_ce;
        end
    end

    // Show the registered head tag only when it carries a request
    assign m_tag_out = m_tag_present ? c_tag : '0;

    a_tag_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_tag_present |-> m_hit) else $error("tag without entry");
    a_enq_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_can_enqueue |-> m_hit) else $error("enqueue flag without entry");
    a_result_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid) else $error("result lost");
endmodule
